>>> rtl/uer_pkg.sv
// Shared types, codes and constants of the ultrasonic echo ranger.
package uer_pkg;

	// Field widths.
	localparam int SPAN_W = 16;
	localparam int TICK_W = 8;
	localparam int DIST_W = 14;

	// Default window depth and reset value of the trigger length register.
	localparam int WINDOW_DEPTH_DEF = 3;
	localparam logic [TICK_W-1:0] TRIG_TICKS_RST = 8'd2;

	// Distance scaling: floor(f * 1715 / 10000) = floor(floor(f * 343 / 16) / 125).
	// The division by 125 is a multiplication by ceil(2^34 / 125) and a shift by 34,
	// which is exact for every dividend below 2^21.
	localparam int X_W = 25;
	localparam int Y_W = 21;
	localparam int P_W = 49;
	localparam logic [8:0] DIST_MUL = 9'd343;
	localparam int DIST_PRE_SHIFT = 4;
	localparam logic [27:0] RECIP_M = 28'd137438954;
	localparam int RECIP_SHIFT = 34;

	// Request codes of an input item.
	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_ECHO  = 2'd2,
		REQ_NONE  = 2'd3
	} uer_req_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DSTART,
		S_DIV,
		S_MUL1,
		S_MUL2,
		S_PUB
	} uer_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic div_start;
		logic filt_load;
		logic mul1;
		logic mul2;
		logic pub;
	} uer_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic completes;
		logic div_done;
	} uer_sts_t;

	// One result item.
	typedef struct packed {
		logic              trig_level;
		logic              echo_armed;
		logic              sample_valid;
		logic [SPAN_W-1:0] echo_span;
		logic [SPAN_W-1:0] filtered_span;
		logic [DIST_W-1:0] distance_mm;
	} uer_res_t;

endpackage

>>> rtl/uer_if.sv
// Channel interfaces of the ultrasonic echo ranger: input items, result items, configuration.
interface uer_meas_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] timer_count;

	modport source (output valid, output req_type, output timer_count, input ready);
	modport sink (input valid, input req_type, input timer_count, output ready);
endinterface

interface uer_result_if;
	logic        valid;
	logic        ready;
	logic        trig_level;
	logic        echo_armed;
	logic        sample_valid;
	logic [15:0] echo_span;
	logic [15:0] filtered_span;
	logic [13:0] distance_mm;

	modport source (output valid, output trig_level, output echo_armed, output sample_valid,
		output echo_span, output filtered_span, output distance_mm, input ready);
	modport sink (input valid, input trig_level, input echo_armed, input sample_valid,
		input echo_span, input filtered_span, input distance_mm, output ready);
endinterface

interface uer_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] trig_ticks;

	modport source (output valid, output trig_ticks, input ready);
	modport sink (input valid, input trig_ticks, output ready);
endinterface

>>> rtl/uer_div.sv
// Restoring divider, one quotient bit per cycle, for the window mean.
module uer_div #(
	parameter int SUM_W = 18,
	parameter int CNT_W = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic [SUM_W-1:0] quotient,
	output logic             done
);

	localparam int IT_W = $clog2(SUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [IT_W-1:0]  cnt_q;
	logic [CNT_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W:0]   trial;
	logic             fits;

	// Bring down the next dividend bit and test the divisor against it.
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= IT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == IT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

>>> rtl/uer_dp.sv
// Datapath of the ultrasonic echo ranger: trigger and capture state, span window, mean, distance.
module uer_dp #(
	parameter int WINDOW_DEPTH = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  uer_pkg::uer_cmd_t cmd,
	output uer_pkg::uer_sts_t sts,
	input  logic [1:0]        req_type,
	input  logic [15:0]       timer_count,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_trig_ticks,
	output uer_pkg::uer_res_t res
);
	import uer_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = SPAN_W + $clog2(WINDOW_DEPTH);

	logic [TICK_W-1:0] trig_ticks_q;
	logic              trig_active_q;
	logic              trig_pend_q;
	logic [TICK_W-1:0] tick_count_q;
	logic              trig_pin_q;
	logic              capture_armed_q;
	logic              echo_phase_q;
	logic [SPAN_W-1:0] start_count_q;
	logic [SPAN_W-1:0] win_q [WINDOW_DEPTH];
	logic [CNT_W-1:0]  fill_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SPAN_W-1:0] last_span_q;
	logic              sample_valid_q;
	logic [SPAN_W-1:0] filt_q;
	logic [X_W-1:0]    x_s1;
	logic [DIST_W-1:0] dist_q;
	uer_res_t          res_q;

	logic [TICK_W-1:0] tick_inc;
	logic [SPAN_W-1:0] span;
	logic [SUM_W-1:0]  quotient;
	logic              div_done;
	logic [Y_W-1:0]    y;
	logic [P_W-1:0]    prod;

	assign tick_inc = tick_count_q + 1'b1;
	assign span     = timer_count - start_count_q;

	// The current item closes an echo span.
	assign sts.completes = (req_type == REQ_ECHO) && capture_armed_q && echo_phase_q;
	assign sts.div_done  = div_done;

	// Trigger length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_ticks_q <= TRIG_TICKS_RST;
		end else if (cfg_we) begin
			trig_ticks_q <= cfg_trig_ticks;
		end
	end

	// Trigger sequencer and echo capture, updated when an item is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_active_q   <= 1'b0;
			trig_pend_q     <= 1'b0;
			tick_count_q    <= '0;
			trig_pin_q      <= 1'b0;
			capture_armed_q <= 1'b0;
			echo_phase_q    <= 1'b0;
			start_count_q   <= '0;
			last_span_q     <= '0;
			sample_valid_q  <= 1'b0;
			fill_q          <= '0;
			sum_q           <= '0;
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.accept) begin
			sample_valid_q <= sts.completes;
			case (uer_req_t'(req_type))
				REQ_START: begin
					trig_active_q <= 1'b1;
					trig_pend_q   <= 1'b1;
				end
				REQ_TICK: begin
					if (trig_active_q) begin
						if (trig_pend_q) begin
							trig_pin_q  <= 1'b1;
							trig_pend_q <= 1'b0;
						end
						if (tick_inc >= trig_ticks_q) begin
							trig_pin_q      <= 1'b0;
							capture_armed_q <= 1'b1;
							echo_phase_q    <= 1'b0;
							trig_active_q   <= 1'b0;
							tick_count_q    <= '0;
						end else begin
							tick_count_q <= tick_inc;
						end
					end
				end
				REQ_ECHO: begin
					if (capture_armed_q) begin
						if (!echo_phase_q) begin
							start_count_q <= timer_count;
							echo_phase_q  <= 1'b1;
						end else begin
							last_span_q     <= span;
							echo_phase_q    <= 1'b0;
							capture_armed_q <= 1'b0;
							// Unfilled entries hold zero, so the running sum
							// always covers exactly the valid samples.
							sum_q <= sum_q + SUM_W'(span) - SUM_W'(win_q[0]);
							for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
								win_q[i] <= win_q[i+1];
							end
							win_q[WINDOW_DEPTH-1] <= span;
							if (fill_q != CNT_W'(WINDOW_DEPTH)) begin
								fill_q <= fill_q + 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Mean of the window: running sum divided by the sample count.
	uer_div #(
		.SUM_W(SUM_W),
		.CNT_W(CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (fill_q),
		.quotient (quotient),
		.done     (div_done)
	);

	// Filtered value and distance in two multiply steps.
	assign y    = x_s1[X_W-1:DIST_PRE_SHIFT];
	assign prod = P_W'(y) * P_W'(RECIP_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
			dist_q <= '0;
		end else begin
			if (cmd.filt_load) begin
				filt_q <= quotient[SPAN_W-1:0];
			end
			if (cmd.mul2) begin
				dist_q <= prod[RECIP_SHIFT +: DIST_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			x_s1 <= X_W'(filt_q) * X_W'(DIST_MUL);
		end
	end

	// Output register; it holds a result while the next item is worked on.
	always_ff @(posedge clk) begin
		if (cmd.pub) begin
			res_q.trig_level    <= trig_pin_q;
			res_q.echo_armed    <= capture_armed_q;
			res_q.sample_valid  <= sample_valid_q;
			res_q.echo_span     <= last_span_q;
			res_q.filtered_span <= filt_q;
			res_q.distance_mm   <= dist_q;
		end
	end

	assign res = res_q;

	// An empty window sums to zero.
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 |-> sum_q == '0)
		else $error("span sum nonzero with empty window");

	// The echo phase is only ever set while capture is armed.
	a_phase_armed: assert property (@(posedge clk) disable iff (!arst_n)
		echo_phase_q |-> capture_armed_q)
		else $error("echo phase set while capture disarmed");

	// The sample count saturates at the window depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_DEPTH))
		else $error("sample count beyond window depth");

endmodule

>>> rtl/uer_ctrl.sv
// Controller state machine of the ultrasonic echo ranger.
module uer_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  uer_pkg::uer_sts_t sts,
	output uer_pkg::uer_cmd_t cmd
);
	import uer_pkg::*;

	uer_state_t state_q;
	uer_state_t state_d;
	logic       out_valid_q;

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.pub) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.completes ? S_DSTART : S_PUB;
				end
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.filt_load = 1'b1;
					state_d       = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_PUB;
			end
			S_PUB: begin
				if (!out_valid_q || out_ready) begin
					cmd.pub = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	// An item that closes a span runs through the divider.
	a_span_divides: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && sts.completes |=> state_q == S_DSTART)
		else $error("completed span skipped the divider");

	// Any other item goes straight to publishing.
	a_plain_publish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && !sts.completes |=> state_q == S_PUB)
		else $error("plain item did not go to publish");

	// The divider result is followed by the distance multiply.
	a_div_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && sts.div_done |=> state_q == S_MUL1)
		else $error("divider result not followed by multiply");

endmodule

>>> rtl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: channels, controller and datapath.
//
//   channel  modport  carries                                        moves on
//   meas     sink     req_type, timer_count                          valid & ready
//   result   source   trig_level, echo_armed, sample_valid,          valid & ready
//                     echo_span, filtered_span, distance_mm
//   cfg      sink     trig_ticks                                     valid & ready
//
// Any item that does not close an echo span is accepted and then loaded for publishing.
// An item that closes an echo span runs through the one-bit-per-cycle window-mean divider,
// then two multiply steps, before publishing. The block takes the next item while a result
// waits, and stalls before publishing until the output register is free; cfg is always
// ready. arst_n clears all but res_q, x_s1 and the divider's rem_q and quo_q.
module ultrasonic_echo_ranger #(
	parameter int WINDOW_DEPTH = uer_pkg::WINDOW_DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	uer_meas_if.sink      meas,
	uer_result_if.source  result,
	uer_cfg_if.sink       cfg
);
	import uer_pkg::*;

	uer_cmd_t cmd;
	uer_sts_t sts;
	uer_res_t res;

	// Configuration writes are taken in any cycle.
	assign cfg.ready = 1'b1;

	uer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (meas.valid),
		.in_ready  (meas.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	uer_dp #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_type       (meas.req_type),
		.timer_count    (meas.timer_count),
		.cfg_we         (cfg.valid),
		.cfg_trig_ticks (cfg.trig_ticks),
		.res            (res)
	);

	// Result item fields.
	assign result.trig_level    = res.trig_level;
	assign result.echo_armed    = res.echo_armed;
	assign result.sample_valid  = res.sample_valid;
	assign result.echo_span     = res.echo_span;
	assign result.filtered_span = res.filtered_span;
	assign result.distance_mm   = res.distance_mm;

endmodule
